// ----- rtl/bfsa_pkg.sv -----
// bfsa_pkg: types, character codes and decode helpers for the block frame scan accumulator
// no dependencies; imported by block_frame_scan_accumulator_top, bfsa_scan_checker and the testbench
package bfsa_pkg;

    // result field widths, fixed by the port list
    localparam int RES_EV_W   = 3;
    localparam int RES_IDX_W  = 12;
    localparam int RES_SUM_W  = 32;
    localparam int RES_SCAN_W = 32;

    // depth of the result queue in front of the output port
    localparam int RES_Q_DEPTH = 3;

    // stream characters
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SEMI  = 8'd59;
    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    // offsets that map a hex letter onto 10..15
    localparam logic [7:0] CH_LA_OFS = 8'h57;
    localparam logic [7:0] CH_UA_OFS = 8'h37;

    // parser phase
    typedef enum logic [2:0] {
        PH_WAIT  = 3'd0,
        PH_COUNT = 3'd1,
        PH_LEN   = 3'd2,
        PH_DATA  = 3'd3,
        PH_FOOT1 = 3'd4,
        PH_FOOT2 = 3'd5
    } phase_t;

    // per-byte event code
    typedef enum logic [RES_EV_W-1:0] {
        EV_FRAME    = 3'd0,
        EV_SAMPLE   = 3'd1,
        EV_SCAN_OK  = 3'd2,
        EV_SCAN_BAD = 3'd3,
        EV_HDR_ERR  = 3'd4,
        EV_SKIP     = 3'd5
    } event_t;

    // one finished result
    typedef struct packed {
        event_t                ev;
        logic [RES_IDX_W-1:0]  idx;
        logic [RES_SUM_W-1:0]  sum;
        logic [RES_SCAN_W-1:0] scans;
    } result_t;

    // hex digit decode: bit 4 set when the byte is a hex digit, bits 3:0 its value
    function automatic logic [4:0] hex_decode(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= CH_ZERO && b <= CH_NINE) begin
            r = {1'b1, 4'(b - CH_ZERO)};
        end else if (b >= CH_LA && b <= CH_LF) begin
            r = {1'b1, 4'(b - CH_LA_OFS)};
        end else if (b >= CH_UA && b <= CH_UF) begin
            r = {1'b1, 4'(b - CH_UA_OFS)};
        end
        return r;
    endfunction

endpackage

// ----- rtl/block_frame_scan_accumulator_top.sv -----
// block_frame_scan_accumulator_top: definite-length block parser with per-index scan sums
// depends on bfsa_pkg and bfsa_ram
//
//  channel  signals                                        direction
//  -------  ---------------------------------------------  ---------
//  in       in_valid, in_ready, data_byte                  into block
//  out      out_valid, out_ready, event_res, sample_index,  out of block
//           running_sum, scans_done
//  cfg      cfg_we, cfg_wdata (sample_signed)              into block
//
// one byte per cycle while in_ready is high; each result is built in order:
// the parser and store read in the transfer cycle, add and write-back in the next,
// then the result queue register. the accumulation store is one ram with a registered
// read. a fill mark stands in for clearing the store, so no clearing pass follows
// reset. with out_ready low the three-entry result queue fills and in_ready drops.
module block_frame_scan_accumulator_top
    import bfsa_pkg::*;
#(
    parameter int STORE_DEPTH    = 4096,
    parameter int MAX_LEN_DIGITS = 4,
    parameter int SUM_WIDTH      = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic                         cfg_wdata,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [7:0]                   data_byte,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [RES_EV_W-1:0]          event_res,
    output logic [RES_IDX_W-1:0]         sample_index,
    output logic signed [RES_SUM_W-1:0]  running_sum,
    output logic [RES_SCAN_W-1:0]        scans_done
);

    localparam int IDX_W  = $clog2(STORE_DEPTH);
    localparam int LEN_W  = IDX_W + 1;
    localparam int PROD_W = IDX_W + 5;
    localparam int DIG_W  = $clog2(MAX_LEN_DIGITS + 1);

    // parser state
    phase_t                phase_reg, phase_next;
    logic [DIG_W-1:0]      digits_left_reg, digits_left_next;
    logic [LEN_W-1:0]      scan_length_reg, scan_length_next;
    logic [LEN_W-1:0]      write_index_reg, write_index_next;
    logic [RES_SCAN_W-1:0] scan_count_reg, scan_count_next;
    logic                  sample_signed_reg;
    event_t                ev_now;

    // execute stage
    logic                  p1_valid_reg;
    event_t                p1_ev_reg;
    logic [LEN_W-1:0]      p1_idx_reg;
    logic [SUM_WIDTH-1:0]  p1_sample_reg;
    logic [RES_SCAN_W-1:0] p1_scans_reg;
    logic [LEN_W-1:0]      fill_reg;

    // result queue
    result_t               res_q [RES_Q_DEPTH];
    logic [1:0]            wr_ptr_reg, rd_ptr_reg, q_cnt_reg;

    logic                  in_fire;
    logic                  pop;
    logic [4:0]            hex;
    logic                  cnt_ok;
    logic                  dec_ok;
    logic [3:0]            dec_val;
    logic [PROD_W-1:0]     len_prod;
    logic                  len_ovf;
    logic [LEN_W-1:0]      len_new;
    logic [DIG_W-1:0]      digits_dec;
    logic [LEN_W-1:0]      idx_inc;
    logic [SUM_WIDTH-1:0]  sample_ext;
    logic [RES_SCAN_W-1:0] scan_inc;

    logic                  p1_is_sample;
    logic                  p1_in_range;
    logic                  ram_we;
    logic [SUM_WIDTH-1:0]  ram_rdata;
    logic [SUM_WIDTH-1:0]  old_sum;
    logic [SUM_WIDTH-1:0]  new_sum;
    result_t               res_new;

    // handshakes
    assign in_fire = in_valid && in_ready;
    assign pop     = out_valid && out_ready;
    assign in_ready = (3'({1'b0, q_cnt_reg}) + 3'(p1_valid_reg)) < 3'(RES_Q_DEPTH);

    // byte decode
    assign hex     = hex_decode(data_byte);
    assign cnt_ok  = hex[4] && (hex[3:0] != 4'd0) && (32'(hex[3:0]) <= MAX_LEN_DIGITS);
    assign dec_ok  = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
    assign dec_val = 4'(data_byte - CH_ZERO);

    // length times ten plus digit
    assign len_prod = (PROD_W'(scan_length_reg) << 3) + (PROD_W'(scan_length_reg) << 1)
                    + PROD_W'(dec_val);
    assign len_ovf  = len_prod > PROD_W'(STORE_DEPTH);
    assign len_new  = LEN_W'(len_prod);

    assign digits_dec = (digits_left_reg != '0) ? digits_left_reg - DIG_W'(1) : '0;
    assign idx_inc    = write_index_reg + LEN_W'(1);
    assign scan_inc   = (scan_count_reg != '1) ? scan_count_reg + RES_SCAN_W'(1)
                                               : scan_count_reg;

    // sample extension
    assign sample_ext = {{(SUM_WIDTH-8){sample_signed_reg && data_byte[7]}}, data_byte};

    // parser next state
    always_comb
    begin
        phase_next       = phase_reg;
        digits_left_next = digits_left_reg;
        scan_length_next = scan_length_reg;
        write_index_next = write_index_reg;
        scan_count_next  = scan_count_reg;
        if (in_fire)
        begin
            unique case (phase_reg)
                PH_WAIT:
                begin
                    if (data_byte == CH_HASH)
                    begin
                        phase_next = PH_COUNT;
                    end
                end
                PH_COUNT:
                begin
                    if (!cnt_ok)
                    begin
                        phase_next = PH_WAIT;
                    end
                    else
                    begin
                        digits_left_next = DIG_W'(hex[3:0]);
                        scan_length_next = '0;
                        phase_next       = PH_LEN;
                    end
                end
                PH_LEN:
                begin
                    if (!dec_ok || len_ovf)
                    begin
                        phase_next = PH_WAIT;
                    end
                    else
                    begin
                        scan_length_next = len_new;
                        digits_left_next = digits_dec;
                        if (digits_dec == '0)
                        begin
                            write_index_next = '0;
                            phase_next       = (len_new == '0) ? PH_FOOT1 : PH_DATA;
                        end
                    end
                end
                PH_DATA:
                begin
                    write_index_next = idx_inc;
                    if (idx_inc >= scan_length_reg)
                    begin
                        phase_next = PH_FOOT1;
                    end
                end
                PH_FOOT1:
                begin
                    if (data_byte == CH_SEMI)
                    begin
                        phase_next = PH_FOOT2;
                    end
                    else
                    begin
                        scan_count_next = scan_inc;
                        phase_next      = PH_WAIT;
                    end
                end
                PH_FOOT2:
                begin
                    scan_count_next = scan_inc;
                    phase_next      = PH_WAIT;
                end
                default:
                begin
                    phase_next = PH_WAIT;
                end
            endcase
        end
    end

    // event for the byte in transfer
    always_comb
    begin
        unique case (phase_reg)
            PH_WAIT:  ev_now = (data_byte == CH_HASH) ? EV_FRAME : EV_SKIP;
            PH_COUNT: ev_now = cnt_ok ? EV_FRAME : EV_HDR_ERR;
            PH_LEN:   ev_now = (!dec_ok || len_ovf) ? EV_HDR_ERR : EV_FRAME;
            PH_DATA:  ev_now = EV_SAMPLE;
            PH_FOOT1: ev_now = (data_byte == CH_SEMI) ? EV_FRAME : EV_SCAN_BAD;
            PH_FOOT2: ev_now = (data_byte == CH_NL) ? EV_SCAN_OK : EV_SCAN_BAD;
            default:  ev_now = EV_SKIP;
        endcase
    end

    // parser and config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_WAIT;
            digits_left_reg   <= '0;
            scan_length_reg   <= '0;
            write_index_reg   <= '0;
            scan_count_reg    <= '0;
            sample_signed_reg <= 1'b1;
        end
        else
        begin
            phase_reg       <= phase_next;
            digits_left_reg <= digits_left_next;
            scan_length_reg <= scan_length_next;
            write_index_reg <= write_index_next;
            scan_count_reg  <= scan_count_next;
            if (cfg_we)
            begin
                sample_signed_reg <= cfg_wdata;
            end
        end
    end

    // execute stage capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= in_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            p1_ev_reg     <= ev_now;
            p1_idx_reg    <= write_index_reg;
            p1_sample_reg <= sample_ext;
            p1_scans_reg  <= scan_count_next;
        end
    end

    // accumulation store: read at transfer, written back in the following cycle;
    // samples of a scan go to rising indices, so a read never meets a pending write
    bfsa_ram #(
        .WIDTH (SUM_WIDTH),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (p1_idx_reg[IDX_W-1:0]),
        .wdata (new_sum),
        .raddr (write_index_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    // add sample; entries at or above the fill mark were never written and read as zero
    assign p1_is_sample = (p1_ev_reg == EV_SAMPLE);
    assign p1_in_range  = p1_idx_reg < LEN_W'(STORE_DEPTH);
    assign old_sum      = (p1_idx_reg < fill_reg) ? ram_rdata : '0;
    assign new_sum      = old_sum + p1_sample_reg;
    assign ram_we       = p1_valid_reg && p1_is_sample && p1_in_range;

    // fill mark
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (ram_we && (p1_idx_reg >= fill_reg))
        begin
            fill_reg <= p1_idx_reg + LEN_W'(1);
        end
    end

    // result assembly
    always_comb
    begin
        res_new.ev    = p1_ev_reg;
        res_new.idx   = '0;
        res_new.sum   = '0;
        res_new.scans = p1_scans_reg;
        if (p1_is_sample)
        begin
            res_new.idx = RES_IDX_W'(p1_idx_reg);
            if (p1_in_range)
            begin
                res_new.sum = RES_SUM_W'(new_sum);
            end
        end
    end

    // result queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            q_cnt_reg  <= '0;
        end
        else
        begin
            if (p1_valid_reg)
            begin
                wr_ptr_reg <= (wr_ptr_reg == 2'(RES_Q_DEPTH - 1)) ? 2'd0 : wr_ptr_reg + 2'd1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == 2'(RES_Q_DEPTH - 1)) ? 2'd0 : rd_ptr_reg + 2'd1;
            end
            if (p1_valid_reg && !pop)
            begin
                q_cnt_reg <= q_cnt_reg + 2'd1;
            end
            else if (!p1_valid_reg && pop)
            begin
                q_cnt_reg <= q_cnt_reg - 2'd1;
            end
        end
    end

    // result queue entries
    always_ff @(posedge clk)
    begin
        if (p1_valid_reg)
        begin
            res_q[wr_ptr_reg] <= res_new;
        end
    end

    // output port
    assign out_valid    = (q_cnt_reg != 2'd0);
    assign event_res    = res_q[rd_ptr_reg].ev;
    assign sample_index = res_q[rd_ptr_reg].idx;
    assign running_sum  = $signed(res_q[rd_ptr_reg].sum);
    assign scans_done   = res_q[rd_ptr_reg].scans;

endmodule

// ----- rtl/bfsa_ram.sv -----
// bfsa_ram: generic simple dual-port ram, one write port and one registered read port
// no dependencies
module bfsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ----- test/bfsa_scan_checker.sv -----
// bfsa_scan_checker: byte-by-byte result predictor and scoreboard for the scan accumulator
// depends on bfsa_pkg; instantiated beside the dut by tb_block_frame_scan_accumulator_top
module bfsa_scan_checker
    import bfsa_pkg::*;
#(
    parameter int STORE_DEPTH    = 4096,
    parameter int MAX_LEN_DIGITS = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic                        cfg_wdata,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic [7:0]                  data_byte,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [RES_EV_W-1:0]         event_res,
    input  logic [RES_IDX_W-1:0]        sample_index,
    input  logic signed [RES_SUM_W-1:0] running_sum,
    input  logic [RES_SCAN_W-1:0]       scans_done,
    output int unsigned                 fail_count,
    output int unsigned                 pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // parser state as the block should hold it
    phase_t                parse_phase;
    logic [3:0]            digits_left;
    int unsigned           scan_len;
    int unsigned           write_idx;
    logic [RES_SUM_W-1:0]  acc_sums [STORE_DEPTH];
    logic [RES_SCAN_W-1:0] scan_total;
    logic                  signed_samples;

    // results owed by the block, oldest first
    result_t               awaited_results [$];

    // completed scans, held at the top value
    function automatic void bump_scans();
        if (scan_total != '1)
            scan_total++;
    endfunction

    // advance the parser by one byte and return the result it owes
    function automatic result_t decode_byte(input logic [7:0] b);
        result_t              r;
        int                   nib;
        int unsigned          len;
        logic [RES_SUM_W-1:0] sample;
        r.ev  = EV_FRAME;
        r.idx = '0;
        r.sum = '0;
        case (parse_phase)
            PH_WAIT:
            begin
                if (b == CH_HASH)
                    parse_phase = PH_COUNT;
                else
                    r.ev = EV_SKIP;
            end
            PH_COUNT:
            begin
                // one hex digit, only 1..MAX_LEN_DIGITS is usable
                if (b >= CH_ZERO && b <= CH_NINE)
                    nib = int'(b - CH_ZERO);
                else if (b >= CH_LA && b <= CH_LF)
                    nib = int'(b - CH_LA) + 10;
                else if (b >= CH_UA && b <= CH_UF)
                    nib = int'(b - CH_UA) + 10;
                else
                    nib = -1;
                if (nib <= 0 || nib > MAX_LEN_DIGITS)
                begin
                    r.ev        = EV_HDR_ERR;
                    parse_phase = PH_WAIT;
                end
                else
                begin
                    digits_left = 4'(nib);
                    scan_len    = 0;
                    parse_phase = PH_LEN;
                end
            end
            PH_LEN:
            begin
                if (b < CH_ZERO || b > CH_NINE)
                begin
                    r.ev        = EV_HDR_ERR;
                    parse_phase = PH_WAIT;
                end
                else
                begin
                    // partial length is checked against the store on every digit
                    len = scan_len * 10 + int'(b - CH_ZERO);
                    if (len > STORE_DEPTH)
                    begin
                        r.ev        = EV_HDR_ERR;
                        parse_phase = PH_WAIT;
                    end
                    else
                    begin
                        scan_len = len;
                        if (digits_left != 0)
                            digits_left--;
                        if (digits_left == 0)
                        begin
                            write_idx   = 0;
                            parse_phase = (scan_len == 0) ? PH_FOOT1 : PH_DATA;
                        end
                    end
                end
            end
            PH_DATA:
            begin
                sample = {{(RES_SUM_W - 8){signed_samples & b[7]}}, b};
                acc_sums[write_idx] = acc_sums[write_idx] + sample;
                r.ev  = EV_SAMPLE;
                r.idx = RES_IDX_W'(write_idx);
                r.sum = acc_sums[write_idx];
                write_idx++;
                if (write_idx >= scan_len)
                    parse_phase = PH_FOOT1;
            end
            PH_FOOT1:
            begin
                if (b == CH_SEMI)
                    parse_phase = PH_FOOT2;
                else
                begin
                    bump_scans();
                    r.ev        = EV_SCAN_BAD;
                    parse_phase = PH_WAIT;
                end
            end
            PH_FOOT2:
            begin
                bump_scans();
                r.ev        = (b == CH_NL) ? EV_SCAN_OK : EV_SCAN_BAD;
                parse_phase = PH_WAIT;
            end
            default:
            begin
                r.ev        = EV_SKIP;
                parse_phase = PH_WAIT;
            end
        endcase
        r.scans = scan_total;
        return r;
    endfunction

    // one field of a result against its expectation
    task automatic check_field(input string field, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want_v, got_v);
            fail_count++;
        end
    endtask

    // watch both channels and the register port
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            parse_phase    = PH_WAIT;
            digits_left    = '0;
            scan_len       = 0;
            write_idx      = 0;
            scan_total     = '0;
            signed_samples = 1'b1;
            for (int i = 0; i < STORE_DEPTH; i++)
                acc_sums[i] = '0;
            awaited_results.delete();
            fail_count    = 0;
            pending_count = 0;
        end
        else
        begin
            if (cfg_we)
                signed_samples = cfg_wdata;
            if (in_valid && in_ready)
                awaited_results.push_back(decode_byte(data_byte));
            if (out_valid && out_ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("result transfer with nothing awaited: event_res %0d", event_res);
                    fail_count++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("event_res", 32'(want.ev), 32'(event_res));
                    check_field("sample_index", 32'(want.idx), 32'(sample_index));
                    check_field("running_sum", want.sum, running_sum);
                    check_field("scans_done", want.scans, scans_done);
                end
            end
            pending_count = awaited_results.size();
        end
    end

endmodule

// ----- test/tb_block_frame_scan_accumulator_top.sv -----
// tb_block_frame_scan_accumulator_top: byte stream stimulus, handshake idling and verdict
// depends on bfsa_pkg, block_frame_scan_accumulator_top and bfsa_scan_checker
module tb_block_frame_scan_accumulator_top
    import bfsa_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CLK_PERIOD     = 8;
    localparam int          STORE_DEPTH    = 4096;
    localparam int          MAX_LEN_DIGITS = 4;
    localparam int          MAX_GAP        = 19;
    localparam int          PHASE_ITEMS    = 500;
    localparam int          HOLD_AT        = 1000;
    localparam int          LONG_HOLD      = 300;
    localparam int          SETTLE_CYCLES  = 4;
    localparam int          DRAIN_CYCLES   = 8;
    localparam int unsigned CYCLE_LIMIT    = 1_000_000;
    // filler byte that is neither a digit nor a footer character
    localparam logic [7:0]  JUNK           = 8'h78;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        cfg_we;
    logic                        cfg_wdata;
    logic                        in_valid;
    logic                        in_ready;
    logic [7:0]                  data_byte;
    logic                        out_valid;
    logic                        out_ready;
    logic [RES_EV_W-1:0]         event_res;
    logic [RES_IDX_W-1:0]        sample_index;
    logic signed [RES_SUM_W-1:0] running_sum;
    logic [RES_SCAN_W-1:0]       scans_done;
    int unsigned                 fail_count;
    int unsigned                 pending_count;

    // bytes waiting to go out, and transfer counts on each side
    logic [7:0]                  byte_stream [$];
    int unsigned                 tx_count    = 0;
    int unsigned                 rx_count    = 0;
    int unsigned                 tx_burst    = 0;
    int unsigned                 rx_burst    = 0;
    int unsigned                 cycle_count = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    block_frame_scan_accumulator_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .event_res    (event_res),
        .sample_index (sample_index),
        .running_sum  (running_sum),
        .scans_done   (scans_done)
    );

    bfsa_scan_checker #(
        .STORE_DEPTH    (STORE_DEPTH),
        .MAX_LEN_DIGITS (MAX_LEN_DIGITS)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .event_res     (event_res),
        .sample_index  (sample_index),
        .running_sum   (running_sum),
        .scans_done    (scans_done),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // idle cycles before the next transfer, with occasional runs of none
    function automatic int unsigned draw_gap(inout int unsigned burst_left);
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0)
            burst_left = $urandom_range(16, 64);
        return $urandom_range(0, MAX_GAP);
    endfunction

    // random byte outside an inclusive range
    function automatic logic [7:0] random_byte_outside(input logic [7:0] lo, input logic [7:0] hi);
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b >= lo && b <= hi);
        return b;
    endfunction

    // hash, digit count and zero-padded length digits
    task automatic push_header(input int unsigned len, input int unsigned ndig);
        int unsigned scale;
        scale = 1;
        repeat (ndig - 1) scale *= 10;
        byte_stream.push_back(CH_HASH);
        byte_stream.push_back(CH_ZERO + 8'(ndig));
        for (int unsigned d = scale; d > 0; d /= 10)
            byte_stream.push_back(CH_ZERO + 8'((len / d) % 10));
    endtask

    // full scan with random samples; the footer is sometimes broken
    task automatic push_scan(input int unsigned len, input int unsigned ndig);
        int unsigned pick;
        push_header(len, ndig);
        repeat (len) byte_stream.push_back(8'($urandom_range(0, 255)));
        pick = $urandom_range(0, 99);
        if (pick < 86)
        begin
            byte_stream.push_back(CH_SEMI);
            byte_stream.push_back(CH_NL);
        end
        else if (pick < 93)
            byte_stream.push_back(random_byte_outside(CH_SEMI, CH_SEMI));
        else
        begin
            byte_stream.push_back(CH_SEMI);
            byte_stream.push_back(random_byte_outside(CH_NL, CH_NL));
        end
    endtask

    // offer every queued byte, one transfer at a time
    task automatic send_stream();
        int unsigned gap;
        while (byte_stream.size() > 0)
        begin
            gap = draw_gap(tx_burst);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid  <= 1'b1;
            data_byte <= byte_stream.pop_front();
            do @(posedge clk); while (!in_ready);
            tx_count++;
        end
    endtask

    // sample mode change once every result is back
    task automatic write_mode(input logic signed_mode);
        in_valid <= 1'b0;
        while (rx_count < tx_count) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= signed_mode;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // mostly good scans, with noise and broken headers mixed in
    task automatic run_random(input int unsigned target);
        int unsigned done_items;
        int unsigned kind;
        int unsigned len;
        int unsigned ndig;
        int unsigned nmin;
        done_items = 0;
        while (done_items < target)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 70)
            begin
                // well-formed scan, mostly short
                case ($urandom_range(0, 9))
                    0:       len = 0;
                    1:       len = $urandom_range(13, 300);
                    default: len = $urandom_range(1, 12);
                endcase
                nmin = (len >= 100) ? 3 : (len >= 10) ? 2 : 1;
                ndig = $urandom_range(nmin, MAX_LEN_DIGITS);
                push_scan(len, ndig);
            end
            else if (kind < 80)
            begin
                // line noise, may carry a stray hash
                repeat ($urandom_range(1, 4))
                    byte_stream.push_back(8'($urandom_range(0, 255)));
            end
            else if (kind < 90)
            begin
                // unusable digit count
                byte_stream.push_back(CH_HASH);
                case ($urandom_range(0, 4))
                    0:       byte_stream.push_back(CH_ZERO);
                    1:       byte_stream.push_back(CH_ZERO + 8'($urandom_range(MAX_LEN_DIGITS + 1, 9)));
                    2:       byte_stream.push_back(CH_LA + 8'($urandom_range(0, 5)));
                    3:       byte_stream.push_back(CH_UA + 8'($urandom_range(0, 5)));
                    default:
                    begin
                        len = random_byte_outside(CH_ZERO, CH_NINE);
                        while ((len >= CH_LA && len <= CH_LF) || (len >= CH_UA && len <= CH_UF))
                            len = random_byte_outside(CH_ZERO, CH_NINE);
                        byte_stream.push_back(8'(len));
                    end
                endcase
            end
            else if (kind < 95)
            begin
                // non-decimal length digit after zero or more good ones
                ndig = $urandom_range(1, MAX_LEN_DIGITS);
                byte_stream.push_back(CH_HASH);
                byte_stream.push_back(CH_ZERO + 8'(ndig));
                repeat ($urandom_range(0, ndig - 1))
                    byte_stream.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                byte_stream.push_back(random_byte_outside(CH_ZERO, CH_NINE));
            end
            else
                // length beyond the store
                push_header($urandom_range(STORE_DEPTH + 1, 9999), MAX_LEN_DIGITS);
            // skipped noise does not count toward the phase
            if (kind < 70 || kind >= 80)
                done_items += byte_stream.size();
            send_stream();
        end
    endtask

    // result side: random stalls plus one long hold-off
    initial
    begin : receiver
        int unsigned gap;
        out_ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            gap = (rx_count == HOLD_AT) ? LONG_HOLD : draw_gap(rx_burst);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            rx_count++;
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // stimulus and verdict
    initial
    begin : stimulus
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= 1'b0;
        in_valid  <= 1'b0;
        data_byte <= 8'h00;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // header corner cases and a short signed scan, reset sample mode
        byte_stream = '{
            8'h00,                                              // skipped while waiting
            CH_HASH, CH_ZERO,                                   // zero digit count
            CH_HASH, CH_LA,                                     // hex count above the limit
            CH_HASH, CH_ZERO + 8'd1, JUNK,                      // non-decimal length digit
            CH_HASH, CH_ZERO + 8'd4, CH_ZERO + 8'd5,
            CH_ZERO, CH_ZERO, CH_ZERO,                          // length over the store
            CH_HASH, CH_ZERO + 8'd1, CH_ZERO, CH_SEMI, CH_NL,   // empty scan
            CH_HASH, CH_ZERO + 8'd1, CH_ZERO + 8'd2,
            8'h80, 8'hFF, JUNK                                  // negative samples, bad footer
        };
        send_stream();

        // unsigned samples
        write_mode(1'b0);
        run_random(PHASE_ITEMS);

        write_mode(1'b1);
        run_random(PHASE_ITEMS);

        write_mode(1'b0);
        run_random(PHASE_ITEMS);

        // drain
        in_valid <= 1'b0;
        while (rx_count < tx_count) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_count != 0)
            $error("%0d results never arrived", pending_count);
        if (fail_count == 0 && pending_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/bfsa_pkg.sv
rtl/bfsa_ram.sv
rtl/block_frame_scan_accumulator_top.sv
test/bfsa_scan_checker.sv
test/tb_block_frame_scan_accumulator_top.sv
